// ----- rtl/can_frame_xtea_cipher_unit_macros.svh -----
// assertion macros used by the cipher unit top level
`ifndef CAN_FRAME_XTEA_CIPHER_UNIT_MACROS_SVH
`define CAN_FRAME_XTEA_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CFX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfx_pkg.sv -----
// types and constants of the can frame xtea cipher unit
package cfx_pkg;

  // added to the round sum once per full round
  localparam logic [31:0] SUM_STEP = 32'h9E37_79B9;

  localparam logic [31:0] KEY0_RESET = 32'hD88C_B272;
  localparam logic [31:0] KEY1_RESET = 32'h285E_CEDE;
  localparam logic [31:0] KEY2_RESET = 32'hB4B5_25AF;
  localparam logic [31:0] KEY3_RESET = 32'h1966_6D97;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } cfx_reg_e;

  typedef logic [3:0][31:0] cfx_key_t;

  // one frame in flight: direction, salted round key and the two words
  typedef struct packed {
    logic     op;
    cfx_key_t key;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } cfx_beat_t;

endpackage

// ----- rtl/can_frame_xtea_cipher_unit.sv -----
// top level of the can frame xtea cipher unit
//
// channel   dir  handshake                beat contents
// s_axis    in   tvalid/tready            tuser: op; tdata: group number, payload words
// m_axis    out  tvalid/tready            tdata: result words
// apb       in   psel/penable/pwrite      key_word0..3 at byte addresses 0, 4, 8, 12
//
// one frame enters per cycle while the skid entry is free; the pipe is a salt
// stage, one stage per half round and an output register
// the salt stage holds the single 32x32 multiply that forms key word one
// reset clears all valid bits and loads the default key words
// a stall at m_axis freezes the whole pipe once the skid entry is full;
// until then frames keep entering
`include "can_frame_xtea_cipher_unit_macros.svh"

module can_frame_xtea_cipher_unit #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [15:0] group_number, [47:16] payload_low,
                                      // [79:48] payload_high
  input  logic        s_axis_tuser,   // [0] op
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] result_low, [63:32] result_high
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfx_pkg::*;

  localparam int unsigned STAGES = 2 * ROUNDS;

  // key registers
  cfx_key_t key_d, key_q;
  cfx_reg_e reg_sel;
  logic     reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfx_reg_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    key_d = key_q;
    if (reg_wr) begin
      case (reg_sel)
        REG_KEY0: key_d[0] = pwdata;
        REG_KEY1: key_d[1] = pwdata;
        REG_KEY2: key_d[2] = pwdata;
        REG_KEY3: key_d[3] = pwdata;
        default:  key_d    = key_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY0: prdata = key_q[0];
      REG_KEY1: prdata = key_q[1];
      REG_KEY2: prdata = key_q[2];
      REG_KEY3: prdata = key_q[3];
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KEY0_RESET;
      key_q[1] <= KEY1_RESET;
      key_q[2] <= KEY2_RESET;
      key_q[3] <= KEY3_RESET;
    end else begin
      key_q <= key_d;
    end
  end

  // pipe advances together while the skid entry is free
  logic               adv;
  logic [STAGES:0]    stg_valid;
  cfx_beat_t          stg_beat [STAGES+1];

  assign s_axis_tready = adv;

  cfx_key_salt u_salt (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (s_axis_tvalid),
    .op_i           (s_axis_tuser),
    .group_number_i (s_axis_tdata[15:0]),
    .payload_low_i  (s_axis_tdata[47:16]),
    .payload_high_i (s_axis_tdata[79:48]),
    .key_i          (key_q),
    .valid_o        (stg_valid[0]),
    .beat_o         (stg_beat[0])
  );

  // one stage per half round; both directions share the stages
  for (genvar i = 0; i < STAGES; i++) begin : g_round
    cfx_half_round #(
      .ROUNDS (ROUNDS),
      .STEP   (i)
    ) u_half (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (stg_valid[i]),
      .beat_i  (stg_beat[i]),
      .valid_o (stg_valid[i+1]),
      .beat_o  (stg_beat[i+1])
    );
  end

  cfx_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[STAGES]),
    .data_i  ({stg_beat[STAGES].word_b, stg_beat[STAGES].word_a}),
    .ready_o (adv),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .ready_i (m_axis_tready)
  );

  // a held pipe keeps every frame where it is
  `CFX_ASSERT_NEXT(a_hold_pipe, clk_i, rst_ni, !adv, $stable(stg_valid), "pipe moved while held")
  // the skid entry only fills behind a waiting result
  `CFX_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, !adv, m_axis_tvalid && !m_axis_tready || $past(!m_axis_tready), "skid full without a stalled result")
  // an accepted beat lands in the salt stage
  `CFX_ASSERT_NEXT(a_entry, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, stg_valid[0], "accepted beat lost at entry")

endmodule

// ----- rtl/cfx_key_salt.sv -----
// entry stage: salts the key with the group number and registers the frame
module cfx_key_salt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              op_i,
  input  logic [15:0]       group_number_i,
  input  logic [31:0]       payload_low_i,
  input  logic [31:0]       payload_high_i,
  input  cfx_pkg::cfx_key_t key_i,
  output logic              valid_o,
  output cfx_pkg::cfx_beat_t beat_o
);
  import cfx_pkg::*;

  logic [31:0] salt;
  cfx_beat_t   beat_d, beat_q;
  logic        valid_q;

  assign salt = {group_number_i, ~group_number_i};

  always_comb begin
    beat_d.op     = op_i;
    beat_d.key[0] = key_i[0] ^ salt;
    beat_d.key[1] = key_i[1] * salt;
    beat_d.key[2] = key_i[2] & salt;
    beat_d.key[3] = key_i[3] | salt;
    beat_d.word_a = payload_low_i;
    beat_d.word_b = payload_high_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- rtl/cfx_half_round.sv -----
// one registered xtea half round, direction chosen per frame
module cfx_half_round #(
  parameter int unsigned ROUNDS = 32,
  parameter int unsigned STEP   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cfx_pkg::cfx_beat_t beat_i,
  output logic               valid_o,
  output cfx_pkg::cfx_beat_t beat_o
);
  import cfx_pkg::*;

  localparam int unsigned RIDX = STEP / 2;
  localparam bit          EVEN = (STEP % 2) == 0;
  localparam int unsigned FMUL = EVEN ? RIDX : RIDX + 1;
  localparam int unsigned BMUL = EVEN ? ROUNDS - RIDX : ROUNDS - RIDX - 1;
  localparam logic [31:0] SUM_F = 32'(64'(SUM_STEP) * 64'(FMUL));
  localparam logic [31:0] SUM_B = 32'(64'(SUM_STEP) * 64'(BMUL));
  localparam logic [1:0]  KI_F  = EVEN ? SUM_F[1:0] : SUM_F[12:11];
  localparam logic [1:0]  KI_B  = EVEN ? SUM_B[12:11] : SUM_B[1:0];

  function automatic logic [31:0] mix_word(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  logic        tgt_is_a;
  logic [31:0] src, tgt, sum, term, nxt;
  logic [1:0]  ki;
  cfx_beat_t   beat_d, beat_q;
  logic        valid_q;

  always_comb begin
    // forward even and backward odd halves update word a
    tgt_is_a = EVEN ^ beat_i.op;
    src      = tgt_is_a ? beat_i.word_b : beat_i.word_a;
    tgt      = tgt_is_a ? beat_i.word_a : beat_i.word_b;
    sum      = beat_i.op ? SUM_B : SUM_F;
    ki       = beat_i.op ? KI_B : KI_F;
    term     = mix_word(src) ^ (sum + beat_i.key[ki]);
    nxt      = beat_i.op ? (tgt - term) : (tgt + term);
    beat_d        = beat_i;
    beat_d.word_a = tgt_is_a ? nxt : beat_i.word_a;
    beat_d.word_b = tgt_is_a ? beat_i.word_b : nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- rtl/cfx_out_skid.sv -----
// output register with a skid entry behind it
module cfx_out_skid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] data_i,
  output logic        ready_o,
  output logic        valid_o,
  output logic [63:0] data_o,
  input  logic        ready_i
);

  logic        out_valid_d, out_valid_q;
  logic        skid_valid_d, skid_valid_q;
  logic [63:0] out_data_d, out_data_q;
  logic [63:0] skid_data_d, skid_data_q;
  logic        arrive;
  logic        drain;

  assign ready_o = !skid_valid_q;
  assign arrive  = valid_i && !skid_valid_q;
  assign drain   = !out_valid_q || ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (ready_i) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (arrive) begin
      if (drain) begin
        out_valid_d = 1'b1;
        out_data_d  = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = data_i;
      end
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

// ----- bench/can_frame_xtea_cipher_unit_tb.sv -----
// self-checking bench for the can frame xtea cipher unit: directed and random frames
module can_frame_xtea_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfx_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  // salt stage, one stage per half round, output register
  localparam int          LATENCY     = 2 * ROUNDS + 2;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_BEATS = 230;

  // one input beat as the bench sees it
  typedef struct packed {
    logic        op;
    logic [15:0] grp;
    logic [31:0] lo;
    logic [31:0] hi;
  } frame_t;

  // the two transformed payload words
  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
  } payload_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;   // [15:0] group_number, [47:16] payload_low,
                                     // [79:48] payload_high
  logic        s_axis_tuser  = 1'b0; // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] result_low, [63:32] result_high
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the key registers, starts at the reset values
  cfx_key_t key_words = {KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET};

  // predicted result words, oldest first
  payload_t expected_payloads [$];

  int mismatches      = 0;
  int cycle_count     = 0;
  // chance in a hundred that the sender idles or the sink stalls in a cycle
  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;

  can_frame_xtea_cipher_unit #(
    .ROUNDS(ROUNDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // xtea round function half: shifts, xor and add back
  function automatic logic [31:0] feistel_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // salted key from the group number, then the full xtea pass in either direction
  function automatic payload_t xtea_frame_result(input frame_t fr);
    logic [31:0] salt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    cfx_key_t    k;
    payload_t    res;
    salt = {fr.grp, ~fr.grp};
    k[0] = key_words[0] ^ salt;
    k[1] = key_words[1] * salt;   // wraps at 32 bits
    k[2] = key_words[2] & salt;
    k[3] = key_words[3] | salt;
    a = fr.lo;
    b = fr.hi;
    if (!fr.op) begin
      s = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        a = a + (feistel_mix(b) ^ (s + k[s[1:0]]));
        s = s + SUM_STEP;
        b = b + (feistel_mix(a) ^ (s + k[s[12:11]]));
      end
    end else begin
      s = SUM_STEP * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        b = b - (feistel_mix(a) ^ (s + k[s[12:11]]));
        s = s - SUM_STEP;
        a = a - (feistel_mix(b) ^ (s + k[s[1:0]]));
      end
    end
    res.low  = a;
    res.high = b;
    return res;
  endfunction

  // one apb transfer; psel stays high so transfers can run back to back
  task automatic apb_access(input logic write, input cfx_reg_e which,
                            input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {which, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (write) begin
      key_words[which] = wdata;
    end else if (prdata !== key_words[which]) begin
      report_mismatch("key register readback", prdata, key_words[which]);
    end
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one frame, with random sender gaps first; tvalid stays up afterwards
  task automatic send_frame(input frame_t fr, output payload_t predicted);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fr.hi, fr.lo, fr.grp};
    s_axis_tuser  <= fr.op;
    predicted = xtea_frame_result(fr);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_payloads.push_back(predicted);
  endtask

  task automatic wait_drained();
    while (expected_payloads.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each accepted beat, then pick the next ready value
  always @(posedge clk_i) begin : result_check
    payload_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_payloads.size() == 0) begin
        report_mismatch("result beat with nothing expected", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_payloads.pop_front();
        if (m_axis_tdata[31:0] !== want.low) begin
          report_mismatch("result_low", m_axis_tdata[31:0], want.low);
        end
        if (m_axis_tdata[63:32] !== want.high) begin
          report_mismatch("result_high", m_axis_tdata[63:32], want.high);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    frame_t      directed_frames [18];
    frame_t      fr;
    payload_t    res;
    payload_t    last_sealed;
    logic [15:0] last_grp;
    bit          have_sealed;
    int          sel;
    logic [31:0] kval;

    // extremes of group number and payload, both directions, mirrored patterns
    directed_frames = '{
      '{1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000},
      '{1'b1, 16'h0000, 32'h0000_0000, 32'h0000_0000},
      '{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{1'b0, 16'hFFFF, 32'h0000_0000, 32'h0000_0000},
      '{1'b1, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{1'b0, 16'h00FF, 32'h0123_4567, 32'h89AB_CDEF},
      '{1'b1, 16'h00FF, 32'h0123_4567, 32'h89AB_CDEF},
      '{1'b0, 16'hFF00, 32'h89AB_CDEF, 32'h0123_4567},
      '{1'b1, 16'hFF00, 32'h89AB_CDEF, 32'h0123_4567},
      '{1'b0, 16'h8000, 32'h8000_0000, 32'h0000_0001},
      '{1'b1, 16'h0001, 32'h0000_0001, 32'h8000_0000},
      '{1'b0, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555},
      '{1'b1, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA},
      '{1'b0, 16'hFEF0, 32'h1357_9BDF, 32'h2468_ACE0},
      '{1'b0, 16'h1234, 32'hFFFF_FFFF, 32'h0000_0000},
      '{1'b1, 16'h1234, 32'h0000_0000, 32'hFFFF_FFFF},
      '{1'b0, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key registers must come up at their defaults
    for (int r = 0; r < 4; r++) begin
      apb_access(1'b0, cfx_reg_e'(r), '0);
    end
    apb_release();

    // directed frames with the default key, no idling
    foreach (directed_frames[i]) begin
      send_frame(directed_frames[i], res);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // new key set while the pipe is empty: zeros, ones, checkerboard, then random
      for (int r = 0; r < 4; r++) begin
        case (p)
          0: begin
            kval = '0;
          end
          1: begin
            kval = '1;
          end
          2: begin
            kval = r[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
          end
          default: begin
            kval = $urandom;
          end
        endcase
        apb_access(1'b1, cfx_reg_e'(r), kval);
      end
      for (int r = 0; r < 4; r++) begin
        apb_access(1'b0, cfx_reg_e'(r), '0);
      end
      apb_release();

      // idling pattern of this phase
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 46;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 46;
        end
        default: begin
          sender_idle_pct = 28;
          sink_stall_pct  = 28;
        end
      endcase

      have_sealed = 1'b0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        sel = $urandom_range(99);
        if (have_sealed && sel < 30) begin
          // decipher a recent ciphertext under the same group number
          fr = '{1'b1, last_grp, last_sealed.low, last_sealed.high};
        end else begin
          fr.op  = 1'($urandom_range(1));
          fr.grp = (sel < 36) ? 16'h0000 : (sel < 42) ? 16'hFFFF : 16'($urandom);
          fr.lo  = (sel % 10 == 1) ? 32'hFFFF_FFFF : $urandom;
          fr.hi  = (sel % 10 == 2) ? 32'h0000_0000 : $urandom;
        end
        send_frame(fr, res);
        if (!fr.op) begin
          last_sealed = res;
          last_grp    = fr.grp;
          have_sealed = 1'b1;
        end
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    // let any stray beat show up before the verdict
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (LATENCY + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
